[rtl/core/qws_pkg.sv]
// Package with the types, character codes and result-list helpers of the quoted word splitter.
`timescale 1ns / 1ps
`default_nettype none

package qws_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR        = 2'd0;
	localparam logic [1:0] KIND_WORD_END    = 2'd1;
	localparam logic [1:0] KIND_QUOTE_ERROR = 2'd2;
	localparam logic [1:0] KIND_DONE        = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_VTAB      = 8'h0B;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_AT        = 8'h40;

	// Most results one input item can cause.
	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_out;
		logic       last;
	} out_t;

	// Results of one item, filled from entry 0 upward.
	typedef struct packed {
		logic [1:0]                 count;
		out_t [MAX_RESULTS-1:0]     res;
	} batch_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
			(c == CH_RETURN) || (c == CH_FORMFEED) || (c == CH_VTAB);
	endfunction

	function automatic logic is_escapable(input logic [7:0] c);
		return is_space(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE) ||
			(c == CH_BACKSLASH) || (c == CH_HASH) || (c == CH_AT);
	endfunction

	// Appends one result at the next free entry.
	function automatic batch_t push(input batch_t b, input logic [1:0] kind,
			input logic [7:0] data);
		batch_t r;
		out_t   o;
		r = b;
		o.kind     = kind;
		o.byte_out = data;
		o.last     = 1'b0;
		unique case (b.count)
			2'd0: r.res[0] = o;
			2'd1: r.res[1] = o;
			2'd2: r.res[2] = o;
			default: r.res[2] = o;
		endcase
		if (b.count != 2'd3) begin
			r.count = b.count + 2'd1;
		end
		return r;
	endfunction

	// Flags the final result of the list.
	function automatic batch_t mark_last(input batch_t b);
		batch_t r;
		r = b;
		unique case (b.count)
			2'd1: r.res[0].last = 1'b1;
			2'd2: r.res[1].last = 1'b1;
			2'd3: r.res[2].last = 1'b1;
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/quoted_word_splitter_core.sv]
// Top level of the quoted word splitter: input register, decoder and result serializer.
`timescale 1ns / 1ps
`default_nettype none

// Shell-style word splitter. Text enters one byte per transfer on the input
// channel and is closed by one transfer with end_of_text set. Each output
// transfer is a word byte, a word end, a done mark or an unterminated-quote
// error; last marks the final output transfer caused by an input item. The
// block accepts one input transfer per cycle while the result register can
// take a list; an item that causes n results holds the output for n transfers,
// so one byte per cycle is sustained whenever the byte yields at most one
// result and out_ready is high, and the output port (one result per cycle)
// sets the rate otherwise. An accepted input transfer passes the input
// register, where the decoder applies the quote and escape flags, and then
// the result register. Items that cause no result (an opening quote, a
// backslash, separating whitespace) still pass through the input register.
module quoted_word_splitter_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire qws_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output qws_pkg::out_t      out_data
);
	import qws_pkg::*;

	// Input register stage.
	in_t    item_s1;
	logic   valid_s1;
	logic   advance;
	logic   ser_can_load;
	batch_t batch;

	// The registered item moves on as soon as the result register can take its
	// list, which includes the cycle in which the last held result is transferred.
	assign advance  = valid_s1 && ser_can_load;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Decoder: updates the quote, word and backslash flags when the item advances.
	qws_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.batch   (batch)
	);

	// Result register: one result per output transfer.
	qws_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.batch_in  (batch),
		.can_load  (ser_can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[rtl/core/qws_decode.sv]
// Quote and escape state with the decoder that turns one item into its list of results.
`timescale 1ns / 1ps
`default_nettype none

module qws_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire qws_pkg::in_t  item,
	input  wire logic          advance,
	output qws_pkg::batch_t    batch
);
	import qws_pkg::*;

	logic in_single_quote_q, in_double_quote_q, word_started_q, pending_backslash_q;
	logic sq_d, dq_d, ws_d, pb_d;
	logic [7:0] c;

	assign c = item.byte_in;

	always_comb begin
		batch_t b;
		b = '0;
		sq_d = in_single_quote_q;
		dq_d = in_double_quote_q;
		ws_d = word_started_q;
		pb_d = pending_backslash_q;
		if (item.end_of_text) begin
			if (pending_backslash_q) begin
				b = push(b, KIND_CHAR, CH_BACKSLASH);
			end
			if (in_single_quote_q || in_double_quote_q) begin
				b = push(b, KIND_QUOTE_ERROR, 8'h00);
			end else begin
				if (word_started_q || pending_backslash_q) begin
					b = push(b, KIND_WORD_END, 8'h00);
				end
				b = push(b, KIND_DONE, 8'h00);
			end
			sq_d = 1'b0;
			dq_d = 1'b0;
			ws_d = 1'b0;
			pb_d = 1'b0;
		end else if (pending_backslash_q) begin
			pb_d = 1'b0;
			ws_d = 1'b1;
			if (!is_escapable(c)) begin
				b = push(b, KIND_CHAR, CH_BACKSLASH);
			end
			b = push(b, KIND_CHAR, c);
		end else if (c == CH_SQUOTE && !in_double_quote_q) begin
			sq_d = !in_single_quote_q;
			ws_d = 1'b1;
		end else if (c == CH_DQUOTE && !in_single_quote_q) begin
			dq_d = !in_double_quote_q;
			ws_d = 1'b1;
		end else if (c == CH_BACKSLASH) begin
			pb_d = 1'b1;
		end else if (!in_single_quote_q && !in_double_quote_q && is_space(c)) begin
			if (word_started_q) begin
				b = push(b, KIND_WORD_END, 8'h00);
				ws_d = 1'b0;
			end
		end else begin
			b = push(b, KIND_CHAR, c);
			ws_d = 1'b1;
		end
		batch = mark_last(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_single_quote_q   <= 1'b0;
			in_double_quote_q   <= 1'b0;
			word_started_q      <= 1'b0;
			pending_backslash_q <= 1'b0;
		end else if (advance) begin
			in_single_quote_q   <= sq_d;
			in_double_quote_q   <= dq_d;
			word_started_q      <= ws_d;
			pending_backslash_q <= pb_d;
		end
	end

	// Both quote kinds can never be open at once.
	a_one_quote: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_single_quote_q && in_double_quote_q))
		else $error("both quote kinds open");

	// Text end returns every flag to its idle value.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.end_of_text |=>
		!in_single_quote_q && !in_double_quote_q && !word_started_q && !pending_backslash_q)
		else $error("state not cleared after end of text");

	// A pending backslash always leaves at least one result with the next item.
	a_bs_result: assert property (@(posedge clk) disable iff (!arst_n)
		pending_backslash_q |-> batch.count != 2'd0)
		else $error("pending backslash produced no result");

endmodule

`default_nettype wire

[rtl/core/qws_serializer.sv]
// Result register that holds one item's results and hands them out one transfer per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module qws_serializer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire qws_pkg::batch_t  batch_in,
	output logic                  can_load,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output qws_pkg::out_t         out_data
);
	import qws_pkg::*;

	logic [1:0]             count_q;
	logic [1:0]             idx_q;
	out_t [MAX_RESULTS-1:0] res_q;
	logic                   take_last;

	assign out_valid = (count_q != 2'd0);
	assign take_last = out_valid && out_ready && (idx_q == count_q - 2'd1);
	assign can_load  = !out_valid || take_last;

	always_comb begin
		unique case (idx_q)
			2'd0: out_data = res_q[0];
			2'd1: out_data = res_q[1];
			2'd2: out_data = res_q[2];
			default: out_data = res_q[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			idx_q   <= 2'd0;
		end else if (load && can_load) begin
			count_q <= batch_in.count;
			idx_q   <= 2'd0;
		end else if (take_last) begin
			count_q <= 2'd0;
			idx_q   <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= batch_in.res;
		end
	end

	// The read position stays inside the held list.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q < count_q)
		else $error("result index beyond held count");

	// The final result of a list carries the last flag, and no other does.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (idx_q == count_q - 2'd1)))
		else $error("last flag misplaced");

	// A fresh list always starts from its first entry.
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load && can_load |=> idx_q == 2'd0)
		else $error("new list not read from its start");

endmodule

`default_nettype wire
